// ----- rtl/mexp_pkg.sv -----
// shared types and constants for the modular exponentiation core
package mexp_pkg;

   // default operand width
   localparam int DEFAULT_WIDTH = 32;

   // reset values of the configuration registers, cut to width where used
   localparam logic [63:0] RESET_MODULUS  = 64'd4294967291;
   localparam logic [63:0] RESET_EXPONENT = 64'd65537;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 2'd1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULT
   } state_type;

endpackage

// ----- rtl/mexp_mulmod.sv -----
// iterative shift-add modular multiplier, one multiplier bit per cycle
module mexp_mulmod #(
   parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;

   logic [WIDTH+1:0] sum;
   logic [WIDTH+1:0] mod_x1;
   logic [WIDTH+1:0] mod_x2;
   logic [WIDTH+1:0] reduced;

   // one step: 2*acc + bit*a, below three times the modulus, then reduce
   always_comb begin
      mod_x1 = {2'b00, modulus};
      mod_x2 = {1'b0, modulus, 1'b0};
      sum    = {1'b0, acc_ff, 1'b0} + (b_ff[WIDTH-1] ? {2'b00, a_ff} : '0);
      if (sum >= mod_x2) begin
         reduced = sum - mod_x2;
      end else if (sum >= mod_x1) begin
         reduced = sum - mod_x1;
      end else begin
         reduced = sum;
      end
   end

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WIDTH - 1);
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
      end else if (busy_ff) begin
         acc_in = reduced[WIDTH-1:0];
         b_in   = {b_ff[WIDTH-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- rtl/modular_exponentiation_core.sv -----
// top level of the modular exponentiation core
// Raises each message to the configured exponent modulo the configured modulus.
// A transaction is taken when start is high and busy is low; the result then
// appears on rsp_result for exactly one cycle with rsp_valid high, and must be
// captured in that cycle since the receiver cannot hold it off. All work goes
// through one shift-add modular multiplier: one product reduces the message,
// then each of the WIDTH exponent bits costs a squaring plus a multiplication
// when the bit is set. A modulus below two answers 0 without using the
// multiplier. The user must write configuration only while busy is low; the
// block itself does not enforce this.
module modular_exponentiation_core #(
   parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [WIDTH-1:0]                     req_message,
   output logic                                 rsp_valid,
   output logic [WIDTH-1:0]                     rsp_result,
   input  logic                                 csr_write_enable,
   input  logic [mexp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WIDTH-1:0]                     csr_write_data
);

   localparam int BW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   mexp_pkg::state_type state_ff, state_in;

   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic [WIDTH-1:0] exponent_ff, exponent_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [BW-1:0]    bit_ff, bit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_result_ff, rsp_result_in;

   logic             mul_start;
   logic [WIDTH-1:0] mul_a;
   logic [WIDTH-1:0] mul_b;
   logic             mul_done;
   logic [WIDTH-1:0] mul_product;

   // configuration registers
   always_comb begin
      modulus_in  = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            mexp_pkg::CSR_MODULUS:  modulus_in  = csr_write_data;
            mexp_pkg::CSR_EXPONENT: exponent_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // shared multiplier
   mexp_mulmod #(
      .WIDTH(WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (modulus_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   // sequencer: reduce base, then square and multiply from the top bit down
   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      bit_in        = bit_ff;
      rsp_valid_in  = 1'b0;
      rsp_result_in = rsp_result_ff;
      mul_start     = 1'b0;
      mul_a         = mul_product;
      mul_b         = mul_product;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (start) begin
               if (modulus_ff < WIDTH'(2)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = '0;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = WIDTH'(1);
                  mul_b     = req_message;
                  state_in  = mexp_pkg::ST_REDUCE;
               end
            end
         end
         mexp_pkg::ST_REDUCE: begin
            if (mul_done) begin
               // running value starts at one, so its first square is one
               base_in   = mul_product;
               bit_in    = BW'(WIDTH - 1);
               mul_start = 1'b1;
               mul_a     = WIDTH'(1);
               mul_b     = WIDTH'(1);
               state_in  = mexp_pkg::ST_SQUARE;
            end
         end
         mexp_pkg::ST_SQUARE: begin
            if (mul_done) begin
               if (exponent_ff[bit_ff]) begin
                  mul_start = 1'b1;
                  mul_b     = base_ff;
                  state_in  = mexp_pkg::ST_MULT;
               end else if (bit_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = mul_product;
                  state_in      = mexp_pkg::ST_IDLE;
               end else begin
                  bit_in    = bit_ff - 1'b1;
                  mul_start = 1'b1;
               end
            end
         end
         mexp_pkg::ST_MULT: begin
            if (mul_done) begin
               if (bit_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = mul_product;
                  state_in      = mexp_pkg::ST_IDLE;
               end else begin
                  bit_in    = bit_ff - 1'b1;
                  mul_start = 1'b1;
                  state_in  = mexp_pkg::ST_SQUARE;
               end
            end
         end
         default: state_in = mexp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         modulus_ff   <= mexp_pkg::RESET_MODULUS[WIDTH-1:0];
         exponent_ff  <= mexp_pkg::RESET_EXPONENT[WIDTH-1:0];
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         exponent_ff  <= exponent_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff       <= base_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign busy       = (state_ff != mexp_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule
